// File: hw/rtl/sil_pkg.sv
// Shared types, codes and sizes of the sorted intercept list.
`default_nettype none

package sil_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned EntryW = 50;

  localparam logic [16:0] OneQ16 = 17'h10000;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpAdd = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;

  localparam logic [2:0] StAdded = 3'd0;
  localparam logic [2:0] StRange = 3'd1;
  localparam logic [2:0] StFull = 3'd2;
  localparam logic [2:0] StNull = 3'd3;
  localparam logic [2:0] StCleared = 3'd4;
  localparam logic [2:0] StEntry = 3'd5;
  localparam logic [2:0] StEmpty = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        kind;
    logic [16:0] distance;
    logic [31:0] object_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        entry_kind;
    logic [16:0] entry_distance;
    logic [31:0] entry_object;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        kind;
    logic [16:0] distance;
    logic [31:0] object_handle;
  } entry_t;

  typedef enum logic [2:0] {
    IdxHold,
    IdxLoadCnt,
    IdxZero,
    IdxDec,
    IdxInc
  } idx_op_e;

  typedef enum logic [1:0] {
    CntHold,
    CntClear,
    CntInc
  } cnt_op_e;

  typedef struct packed {
    logic       load_item;
    idx_op_e    idx_op;
    cnt_op_e    cnt_op;
    logic       ram_re;
    logic       rd_prev;
    logic       ram_we;
    logic       wr_new;
    logic       out_load;
    logic [2:0] out_status;
    logic       out_entry;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       obj_null;
    logic       dist_over;
    logic       full;
    logic       empty;
    logic       idx_zero;
    logic       prev_gt;
    logic       rd_last;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/sil_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module sil_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sil_ctrl.sv
// Controller state machine of the sorted intercept list.
`default_nettype none

module sil_ctrl import sil_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    Idle,
    Decode,
    Emit,
    InsCheck,
    InsCmp,
    RdReq,
    RdOut
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] status_q, status_d;

  assign in_stall_o = (state_q != Idle);

  always_comb begin
    state_d = state_q;
    status_d = status_q;
    cmd_o.load_item = 1'b0;
    cmd_o.idx_op = IdxHold;
    cmd_o.cnt_op = CntHold;
    cmd_o.ram_re = 1'b0;
    cmd_o.rd_prev = 1'b0;
    cmd_o.ram_we = 1'b0;
    cmd_o.wr_new = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.out_status = status_q;
    cmd_o.out_entry = 1'b0;
    cmd_o.out_last = 1'b1;
    case (state_q)
      Idle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = Decode;
        end
      end
      Decode: begin
        case (sts_i.opcode)
          OpClear: begin
            cmd_o.cnt_op = CntClear;
            status_d = StCleared;
            state_d = Emit;
          end
          OpAdd: begin
            if (sts_i.obj_null) begin
              status_d = StNull;
              state_d = Emit;
            end else if (sts_i.dist_over) begin
              status_d = StRange;
              state_d = Emit;
            end else if (sts_i.full) begin
              status_d = StFull;
              state_d = Emit;
            end else begin
              cmd_o.idx_op = IdxLoadCnt;
              state_d = InsCheck;
            end
          end
          OpRead: begin
            if (sts_i.empty) begin
              status_d = StEmpty;
              state_d = Emit;
            end else begin
              cmd_o.idx_op = IdxZero;
              state_d = RdReq;
            end
          end
          default: begin
            state_d = Idle;
          end
        endcase
      end
      Emit: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = Idle;
        end
      end
      InsCheck: begin
        if (sts_i.idx_zero) begin
          cmd_o.ram_we = 1'b1;
          cmd_o.wr_new = 1'b1;
          cmd_o.cnt_op = CntInc;
          status_d = StAdded;
          state_d = Emit;
        end else begin
          cmd_o.ram_re = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d = InsCmp;
        end
      end
      InsCmp: begin
        cmd_o.ram_we = 1'b1;
        if (sts_i.prev_gt) begin
          cmd_o.idx_op = IdxDec;
          state_d = InsCheck;
        end else begin
          cmd_o.wr_new = 1'b1;
          cmd_o.cnt_op = CntInc;
          status_d = StAdded;
          state_d = Emit;
        end
      end
      RdReq: begin
        cmd_o.ram_re = 1'b1;
        state_d = RdOut;
      end
      RdOut: begin
        cmd_o.out_status = StEntry;
        cmd_o.out_entry = 1'b1;
        cmd_o.out_last = sts_i.rd_last;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.rd_last) begin
            state_d = Idle;
          end else begin
            cmd_o.idx_op = IdxInc;
            state_d = RdReq;
          end
        end
      end
      default: begin
        state_d = Idle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      status_q <= StAdded;
    end else begin
      state_q <= state_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sil_dp.sv
// Datapath of the sorted intercept list: item, count, index, entry RAM and output register.
`default_nettype none

module sil_dp import sil_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_data_i,
  input  wire dp_cmd_t   cmd_i,
  output dp_sts_t        sts_o,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output out_item_t      out_data_o
);

  in_item_t        item_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  out_item_t       out_q;
  entry_t          rdata;
  entry_t          new_entry;
  entry_t          wdata;
  logic [IdxW-1:0] raddr;

  assign new_entry.kind = item_q.kind;
  assign new_entry.distance = item_q.distance;
  assign new_entry.object_handle = item_q.object_handle;

  assign wdata = cmd_i.wr_new ? new_entry : rdata;
  assign raddr = cmd_i.rd_prev ? (idx_q - IdxW'(1)) : idx_q;

  sil_ram #(
    .WIDTH(EntryW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we),
    .waddr_i(idx_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    case (cmd_i.idx_op)
      IdxLoadCnt: idx_q <= cnt_q[IdxW-1:0];
      IdxZero:    idx_q <= '0;
      IdxDec:     idx_q <= idx_q - IdxW'(1);
      IdxInc:     idx_q <= idx_q + IdxW'(1);
      default:    idx_q <= idx_q;
    endcase
    if (cmd_i.out_load) begin
      out_q.status <= cmd_i.out_status;
      out_q.entry_kind <= cmd_i.out_entry ? rdata.kind : 1'b0;
      out_q.entry_distance <= cmd_i.out_entry ? rdata.distance : 17'd0;
      out_q.entry_object <= cmd_i.out_entry ? rdata.object_handle : 32'd0;
      out_q.last <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.cnt_op)
        CntClear: cnt_q <= '0;
        CntInc:   cnt_q <= cnt_q + CntW'(1);
        default:  cnt_q <= cnt_q;
      endcase
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.opcode = item_q.opcode;
  assign sts_o.obj_null = (item_q.object_handle == 32'd0);
  assign sts_o.dist_over = (item_q.distance > OneQ16);
  assign sts_o.full = (cnt_q >= CntW'(CAPACITY));
  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.prev_gt = (rdata.distance > item_q.distance);
  assign sts_o.rd_last = ((CntW'(idx_q) + CntW'(1)) == cnt_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_intercept_list_unit.sv
// Top level of the sorted intercept list: controller, datapath and ports.
//
//   Channel | Direction | Handshake              | Beat
//   in      | input     | in_valid_i / in_stall_o  | in_item_t: opcode, kind, distance, handle
//   out     | output    | out_valid_o / out_stall_i | out_item_t: status, entry fields, last
//
// One input beat is taken at a time; the next is taken once the last result is registered.
// Clear, rejected adds and reads of an empty list go from Decode to Emit. An add reads each
// stored entry of greater distance, writes it one place up, then puts the new entry in the gap.
// Each shifted entry costs a RAM read then a write; read out fetches entries one at a time.
// Reset empties the list at once; the entry RAM needs no clearing pass.
// A stalled output holds its beat, and the controller waits until the register frees.
`default_nettype none

module sorted_intercept_list_unit import sil_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sil_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sil_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sil_checker.sv
// Port-level checks of the sorted intercept list and their binding to the top level.
`default_nettype none

module sil_checker import sil_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("Stalled input beat changed.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output beat changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input taken again straight after a beat.");

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StEntry) |->
      out_data_o.last && (out_data_o.entry_kind == 1'b0) &&
      (out_data_o.entry_distance == 17'd0) && (out_data_o.entry_object == 32'd0))
    else $error("Status result carries entry fields or lacks last.");

  a_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StEntry) |->
      (out_data_o.entry_distance <= OneQ16) && (out_data_o.entry_object != 32'd0))
    else $error("Emitted entry holds a distance or handle that add rejects.");

endmodule

bind sorted_intercept_list_unit sil_checker u_sil_checker (.*);

`default_nettype wire

// File: tb/sorted_intercept_list_unit_test.sv
// Self-checking testbench of the sorted intercept list: directed table, then random traces.
`timescale 1ns / 1ps

module sorted_intercept_list_unit_test import sil_pkg::*;;

  localparam logic [1:0] OpNone = 2'd3;
  localparam int unsigned RandomItems = 380;
  localparam int unsigned DrainCycles = 2 * CAPACITY + 40;
  localparam int unsigned CycleLimit = 1000000;

  localparam out_item_t WantAdded = {StAdded, 1'b0, 17'd0, 32'd0, 1'b1};
  localparam out_item_t WantRange = {StRange, 1'b0, 17'd0, 32'd0, 1'b1};
  localparam out_item_t WantFull = {StFull, 1'b0, 17'd0, 32'd0, 1'b1};
  localparam out_item_t WantNull = {StNull, 1'b0, 17'd0, 32'd0, 1'b1};
  localparam out_item_t WantCleared = {StCleared, 1'b0, 17'd0, 32'd0, 1'b1};
  localparam out_item_t WantEmpty = {StEmpty, 1'b0, 17'd0, 32'd0, 1'b1};
  localparam out_item_t Unused = '0;

  localparam logic Typed = 1'b1;
  localparam logic Predicted = 1'b0;

  typedef struct packed {
    logic      fixed_want;
    in_item_t  item;
    out_item_t want;
  } stim_row_t;

  localparam int NumRows = 18;
  localparam stim_row_t DirectedRows [NumRows] = '{
    {Typed,     OpRead,  1'b0, 17'd0,     32'h0000_0000, WantEmpty},
    {Typed,     OpClear, 1'b0, 17'd0,     32'h0000_0000, WantCleared},
    {Typed,     OpAdd,   1'b0, 17'd0,     32'h0000_0000, WantNull},
    {Typed,     OpAdd,   1'b1, 17'h1FFFF, 32'h0000_0000, WantNull},
    {Typed,     OpAdd,   1'b0, 17'h10001, 32'h0000_0001, WantRange},
    {Typed,     OpAdd,   1'b1, 17'h1FFFF, 32'hFFFF_FFFF, WantRange},
    {Typed,     OpAdd,   1'b1, OneQ16,    32'hFFFF_FFFF, WantAdded},
    {Typed,     OpAdd,   1'b0, 17'd0,     32'h0000_0001, WantAdded},
    {Predicted, OpAdd,   1'b1, 17'd0,     32'h0000_0002, Unused},
    {Predicted, OpAdd,   1'b0, 17'h08000, 32'h5555_5555, Unused},
    {Predicted, OpAdd,   1'b1, OneQ16,    32'hAAAA_AAAA, Unused},
    {Predicted, OpAdd,   1'b0, 17'h00001, 32'h8000_0000, Unused},
    {Predicted, OpAdd,   1'b1, 17'h0FFFF, 32'h7FFF_FFFF, Unused},
    {Predicted, OpRead,  1'b0, 17'd0,     32'h0000_0000, Unused},
    {Predicted, OpNone,  1'b1, 17'h1FFFF, 32'hFFFF_FFFF, Unused},
    {Predicted, OpRead,  1'b1, 17'h1FFFF, 32'hFFFF_FFFF, Unused},
    {Typed,     OpClear, 1'b1, 17'h1FFFF, 32'hFFFF_FFFF, WantCleared},
    {Typed,     OpRead,  1'b0, 17'd0,     32'h0000_0000, WantEmpty}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  entry_t      shadow_list [$];
  out_item_t   due_results [$];
  int unsigned beats_sent = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  bit          burst_mode = 1'b0;

  sorted_intercept_list_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void step_intercept_list(input in_item_t it, input bit record);
    int     pos;
    entry_t fresh;
    out_item_t res [$];
    case (it.opcode)
      OpClear: begin
        shadow_list.delete();
        res.push_back(WantCleared);
      end
      OpAdd: begin
        if (it.object_handle == '0) begin
          res.push_back(WantNull);
        end else if (it.distance > OneQ16) begin
          res.push_back(WantRange);
        end else if (shadow_list.size() >= CAPACITY) begin
          res.push_back(WantFull);
        end else begin
          pos = 0;
          while (pos < shadow_list.size() && shadow_list[pos].distance <= it.distance) pos++;
          fresh = {it.kind, it.distance, it.object_handle};
          shadow_list.insert(pos, fresh);
          res.push_back(WantAdded);
        end
      end
      OpRead: begin
        if (shadow_list.size() == 0) begin
          res.push_back(WantEmpty);
        end else begin
          foreach (shadow_list[i]) begin
            res.push_back({StEntry, shadow_list[i].kind, shadow_list[i].distance,
                           shadow_list[i].object_handle, 1'(i == shadow_list.size() - 1)});
          end
        end
      end
      default: ;
    endcase
    if (record) begin
      foreach (res[i]) due_results.push_back(res[i]);
    end
  endfunction

  task automatic send_beat(input in_item_t it, input logic fixed, input out_item_t want);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    step_intercept_list(it, !fixed);
    if (fixed) due_results.push_back(want);
    if (it.opcode != OpNone) beats_sent++;
  endtask

  function automatic in_item_t draw_noise();
    in_item_t it;
    it.kind = 1'($urandom_range(0, 1));
    it.distance = 17'($urandom_range(0, 17'h1FFFF));
    it.object_handle = $urandom;
    case ($urandom_range(0, 2))
      0: begin
        it.opcode = OpAdd;
        it.object_handle = '0;
      end
      1: begin
        it.opcode = OpAdd;
        it.distance = 17'($urandom_range(OneQ16 + 1, 17'h1FFFF));
      end
      default: it.opcode = OpNone;
    endcase
    return it;
  endfunction

  function automatic in_item_t draw_add(input logic [16:0] hot);
    in_item_t it;
    it.opcode = OpAdd;
    it.kind = 1'($urandom_range(0, 1));
    it.object_handle = $urandom;
    if (it.object_handle == '0) it.object_handle = 32'd1;
    case ($urandom_range(0, 5))
      0: it.distance = hot;
      1: it.distance = '0;
      2: it.distance = OneQ16;
      3: it.distance = 17'($urandom_range(0, 3));
      default: it.distance = 17'($urandom_range(0, OneQ16));
    endcase
    return it;
  endfunction

  // After each beat the receiver raises the stall again for a random hold, which is zero in burst mode.
  initial begin
    int unsigned hold;
    forever begin
      hold = burst_mode ? 0 : $urandom_range(0, 10);
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("result beat with nothing due: status %0d", out_data_o.status);
        failures++;
      end else begin
        want = due_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          failures++;
        end
        if (out_data_o.entry_kind !== want.entry_kind) begin
          $error("entry_kind: expected %0d, got %0d", want.entry_kind, out_data_o.entry_kind);
          failures++;
        end
        if (out_data_o.entry_distance !== want.entry_distance) begin
          $error("entry_distance: expected %0h, got %0h", want.entry_distance,
                 out_data_o.entry_distance);
          failures++;
        end
        if (out_data_o.entry_object !== want.entry_object) begin
          $error("entry_object: expected %0h, got %0h", want.entry_object,
                 out_data_o.entry_object);
          failures++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data_o.last);
          failures++;
        end
      end
    end
  end

  initial begin
    in_item_t    it;
    logic [16:0] hot;
    int unsigned count;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[r]) begin
      send_beat(DirectedRows[r].item, DirectedRows[r].fixed_want, DirectedRows[r].want);
    end

    // Each trace clears the list now and then, adds a burst of intercepts and reads them out.
    while (beats_sent < NumRows + RandomItems) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      hot = 17'($urandom_range(0, OneQ16));
      if ($urandom_range(0, 2) != 0) begin
        it = draw_noise();
        it.opcode = OpClear;
        send_beat(it, Predicted, Unused);
      end
      count = ($urandom_range(0, 2) == 0) ? CAPACITY + $urandom_range(1, 3)
                                           : $urandom_range(1, 20);
      for (int unsigned k = 0; k < count; k++) begin
        it = ($urandom_range(0, 7) == 0) ? draw_noise() : draw_add(hot);
        send_beat(it, Predicted, Unused);
        if ($urandom_range(0, 19) == 0) begin
          it = draw_noise();
          it.opcode = OpRead;
          send_beat(it, Predicted, Unused);
        end
      end
      it = draw_noise();
      it.opcode = OpRead;
      send_beat(it, Predicted, Unused);
    end
    burst_mode = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
